@@ design/ira_pkg.sv @@
// Package for the interval range ALU: opcodes, field widths, shared constants.
// No dependencies.
package ira_pkg;

    localparam int DATA_W_DEF = 64;
    localparam int OP_W       = 4;
    localparam int BITS_W     = 7;

    localparam logic [OP_W-1:0] OP_MEET  = 4'd0;
    localparam logic [OP_W-1:0] OP_JOIN  = 4'd1;
    localparam logic [OP_W-1:0] OP_CONST = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd5;
    localparam logic [OP_W-1:0] OP_AND   = 4'd6;
    localparam logic [OP_W-1:0] OP_OR    = 4'd7;
    localparam logic [OP_W-1:0] OP_SHL   = 4'd8;
    localparam logic [OP_W-1:0] OP_SHR   = 4'd9;
    localparam logic [OP_W-1:0] OP_ZEXT  = 4'd10;
    localparam logic [OP_W-1:0] OP_SEXT  = 4'd11;
    localparam logic [OP_W-1:0] OP_TRUNC = 4'd12;
    localparam logic [OP_W-1:0] OP_UBITS = 4'd13;
    localparam logic [OP_W-1:0] OP_SBITS = 4'd14;

    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // one result interval with its type hint
    typedef struct packed {
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic               hvalid;
        logic [BITS_W-1:0]  hwidth;
        logic               hsigned;
    } res_t;

endpackage

@@ design/ira_mul64.sv @@
// Pipelined signed 64x64 multiply with overflow flag, four 32x32 partial products.
// No package dependencies; three register stages, stall by enable.
module ira_mul64
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p,
    output logic               ovf
);
    // stage 1: magnitudes and sign
    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg, zero_reg;
    // stage 2: partial products
    logic [63:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic        neg2_reg, zero2_reg;
    // stage 3: result
    logic signed [63:0] p_reg;
    logic               ovf_reg;

    logic [63:0] ma_next, mb_next;
    logic [97:0] mid, sum;
    logic [63:0] mag;
    logic        big;

    always_comb
    begin
        ma_next = a[63] ? (64'd0 - a) : a;
        mb_next = b[63] ? (64'd0 - b) : b;
    end

    // combine partials: hi*hi nonzero overflows at once
    always_comb
    begin
        mid = {34'd0, plh_reg} + {34'd0, phl_reg} + {66'd0, pll_reg[63:32]};
        sum = mid;
        big = (phh_reg != 64'd0) || (sum[97:32] != 66'd0);
        mag = {sum[31:0], pll_reg[31:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            neg_reg   <= a[63] ^ b[63];
            zero_reg  <= (a == 64'sd0) || (b == 64'sd0);
            pll_reg   <= ma_reg[31:0]  * mb_reg[31:0];
            plh_reg   <= ma_reg[31:0]  * mb_reg[63:32];
            phl_reg   <= ma_reg[63:32] * mb_reg[31:0];
            phh_reg   <= ma_reg[63:32] * mb_reg[63:32];
            neg2_reg  <= neg_reg;
            zero2_reg <= zero_reg;
            if (zero2_reg)
            begin
                p_reg   <= 64'sd0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                p_reg   <= neg2_reg ? (64'sd0 - $signed(mag)) : $signed(mag);
                ovf_reg <= big || (neg2_reg ? (mag > 64'h8000_0000_0000_0000)
                                            : mag[63]);
            end
        end
    end

    assign p   = p_reg;
    assign ovf = ovf_reg;
endmodule

@@ design/interval_range_alu.sv @@
// Interval range ALU top level: input decode, four corner multipliers, result select, hint.
// Depends on ira_pkg and ira_mul64.
//
// Usage: items arrive on the s_axis channel (tdata carries opcode, the A and B bounds
// and the bit count), results leave on m_axis (tdata: res_min, res_max; tuser: hint).
// One result per item, in order. Five register stages: decode, three multiplier
// stages, then select and hint. An item can be taken in every cycle, sustained one
// per cycle while the receiver does not stall; the three-stage 64-bit multiplier
// sets the depth.
// The pipeline advances when the output register is empty or being taken; when the
// receiver stalls the whole pipe holds, so s_axis_tready drops and nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
module interval_range_alu
#(
    parameter int DATA_WIDTH = ira_pkg::DATA_W_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[3:0], a_min[67:4], a_max[131:68], b_min[195:132], b_max[259:196],
    // bit_count[266:260], zero fill to 272
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_min[63:0], res_max[127:64]
    output logic [127:0] m_axis_tdata,
    // hint_valid[0], hint_width[7:1], hint_signed[8]
    output logic [8:0]   m_axis_tuser
);
    import ira_pkg::*;

    localparam int NST = 5;

    logic adv;
    logic [NST-1:0] vld_reg;

    // pass-through payload per stage
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic signed [63:0] al, ah, bl, bh;
        logic [BITS_W-1:0]  bits;
    } item_t;

    item_t it_reg [NST-1];
    item_t in_it;
    res_t  out_reg, rn;

    assign adv = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        in_it.op   = s_axis_tdata[3:0];
        in_it.al   = s_axis_tdata[67:4];
        in_it.ah   = s_axis_tdata[131:68];
        in_it.bl   = s_axis_tdata[195:132];
        in_it.bh   = s_axis_tdata[259:196];
        in_it.bits = s_axis_tdata[266:260];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0] <= in_it;
            for (int i = 1; i < NST-1; i++)
                it_reg[i] <= it_reg[i-1];
        end
    end

    // stage 1 operand choice from the decoded item: corners for mul, 2**s for shl
    logic signed [63:0] ma_next [4];
    logic signed [63:0] mb_next [4];
    logic signed [63:0] shm;
    logic [5:0]         sh_s;

    assign sh_s = it_reg[0].bl[5:0];
    always_comb
    begin
        shm = 64'sd1 <<< sh_s;
        if (it_reg[0].op == OP_SHL)
        begin
            ma_next[0] = it_reg[0].al; mb_next[0] = shm;
            ma_next[1] = it_reg[0].ah; mb_next[1] = shm;
            ma_next[2] = it_reg[0].al; mb_next[2] = shm;
            ma_next[3] = it_reg[0].ah; mb_next[3] = shm;
        end
        else
        begin
            ma_next[0] = it_reg[0].al; mb_next[0] = it_reg[0].bl;
            ma_next[1] = it_reg[0].al; mb_next[1] = it_reg[0].bh;
            ma_next[2] = it_reg[0].ah; mb_next[2] = it_reg[0].bl;
            ma_next[3] = it_reg[0].ah; mb_next[3] = it_reg[0].bh;
        end
    end

    logic signed [63:0] pr [4];
    logic               po [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_mul
        ira_mul64 u_mul
        (
            .clk (clk),
            .en  (adv),
            .a   (ma_next[g]),
            .b   (mb_next[g]),
            .p   (pr[g]),
            .ovf (po[g])
        );
    end

    // stage 4: final result from the item and multiplier outputs
    item_t x;
    logic signed [63:0] lo, hi, mlo0, mlo1, mhi0, mhi1, sr_lo, sr_hi, mask, t;
    logic               a_top, b_top, ovf_a, ovf_s, sh_ok;
    logic [6:0]         cb;
    logic [64:0]        sa, sb;

    always_comb
    begin
        x     = it_reg[NST-2];
        a_top = (x.al == S64_MIN) && (x.ah == S64_MAX);
        b_top = (x.bl == S64_MIN) && (x.bh == S64_MAX);
        cb    = (x.bits == 7'd0) ? 7'd1 : ((x.bits > 7'd64) ? 7'd64 : x.bits);
        if (cb >= 7'd64)
        begin
            sr_lo = S64_MIN;
            sr_hi = S64_MAX;
        end
        else
        begin
            sr_hi = (64'sd1 <<< (cb[5:0] - 6'd1)) - 64'sd1;
            sr_lo = ~sr_hi;
        end
        sh_ok = (x.bl == x.bh) && (x.bl >= 64'sd0)
                && (x.bl < 64'(DATA_WIDTH));
        lo = S64_MIN;
        hi = S64_MAX;
        sa = 65'd0;
        sb = 65'd0;
        ovf_a = 1'b0;
        ovf_s = 1'b0;
        mask = '0;
        t = '0;
        mlo0 = (pr[0] < pr[1]) ? pr[0] : pr[1];
        mlo1 = (pr[2] < pr[3]) ? pr[2] : pr[3];
        mhi0 = (pr[0] > pr[1]) ? pr[0] : pr[1];
        mhi1 = (pr[2] > pr[3]) ? pr[2] : pr[3];
        case (x.op)
            OP_MEET:
            begin
                lo = (x.al > x.bl) ? x.al : x.bl;
                hi = (x.ah < x.bh) ? x.ah : x.bh;
            end
            OP_JOIN:
            begin
                if (x.al > x.ah)
                begin
                    lo = x.bl; hi = x.bh;
                end
                else if (x.bl > x.bh)
                begin
                    lo = x.al; hi = x.ah;
                end
                else
                begin
                    lo = (x.al < x.bl) ? x.al : x.bl;
                    hi = (x.ah > x.bh) ? x.ah : x.bh;
                end
            end
            OP_CONST:
            begin
                lo = x.al; hi = x.al;
            end
            OP_ADD:
            begin
                sa = {x.al[63], x.al} + {x.bl[63], x.bl};
                sb = {x.ah[63], x.ah} + {x.bh[63], x.bh};
                ovf_a = (sa[64] != sa[63]) || (sb[64] != sb[63]);
                if (!(a_top || b_top || ovf_a))
                begin
                    lo = sa[63:0]; hi = sb[63:0];
                end
            end
            OP_SUB:
            begin
                sa = {x.al[63], x.al} - {x.bh[63], x.bh};
                sb = {x.ah[63], x.ah} - {x.bl[63], x.bl};
                ovf_s = (sa[64] != sa[63]) || (sb[64] != sb[63]);
                if (!(a_top || b_top || ovf_s))
                begin
                    lo = sa[63:0]; hi = sb[63:0];
                end
            end
            OP_MUL:
            begin
                if (a_top || b_top)
                begin
                    lo = S64_MIN; hi = S64_MAX;
                end
                else if ((x.al == 0 && x.ah == 0) || (x.bl == 0 && x.bh == 0))
                begin
                    lo = 64'sd0; hi = 64'sd0;
                end
                else if (x.al == 1 && x.ah == 1)
                begin
                    lo = x.bl; hi = x.bh;
                end
                else if (x.bl == 1 && x.bh == 1)
                begin
                    lo = x.al; hi = x.ah;
                end
                else if (!(po[0] || po[1] || po[2] || po[3]))
                begin
                    lo = (mlo0 < mlo1) ? mlo0 : mlo1;
                    hi = (mhi0 > mhi1) ? mhi0 : mhi1;
                end
            end
            OP_AND:
            begin
                if (!x.al[63] && !x.bl[63])
                begin
                    lo = 64'sd0; hi = (x.ah < x.bh) ? x.ah : x.bh;
                end
            end
            OP_OR:
            begin
                if (!x.al[63] && !x.bl[63])
                begin
                    lo = 64'sd0; hi = x.ah | x.bh;
                end
            end
            OP_SHL:
            begin
                if (sh_ok && !po[0] && !po[1])
                begin
                    lo = pr[0]; hi = pr[1];
                end
            end
            OP_SHR:
            begin
                if (sh_ok)
                begin
                    lo = x.al >>> x.bl[5:0];
                    hi = x.ah >>> x.bl[5:0];
                end
            end
            OP_ZEXT:
            begin
                mask = (x.bits >= 7'(DATA_WIDTH)) ? '1
                       : ((64'sd1 <<< x.bits[5:0]) - 64'sd1);
                lo = x.al[63] ? 64'sd0 : x.al;
                hi = ($unsigned(x.ah) < $unsigned(mask)) ? x.ah : mask;
            end
            OP_SEXT:
            begin
                lo = (x.al > sr_lo) ? x.al : sr_lo;
                hi = (x.ah < sr_hi) ? x.ah : sr_hi;
            end
            OP_TRUNC:
            begin
                if (x.al >= sr_lo && x.ah <= sr_hi)
                begin
                    lo = x.al; hi = x.ah;
                end
                else
                begin
                    lo = sr_lo; hi = sr_hi;
                end
            end
            OP_UBITS:
            begin
                lo = 64'sd0;
                if (x.bits >= 7'(DATA_WIDTH - 1))
                    hi = S64_MAX;
                else
                begin
                    t = (64'sd1 <<< x.bits[5:0]) - 64'sd1;
                    hi = t;
                end
            end
            OP_SBITS:
            begin
                if (x.bits < 7'(DATA_WIDTH))
                begin
                    lo = sr_lo; hi = sr_hi;
                end
            end
            default:
            begin
                lo = S64_MIN; hi = S64_MAX;
            end
        endcase

        // narrowest type hint
        rn.lo = lo;
        rn.hi = hi;
        rn.hvalid = 1'b0;
        rn.hwidth = 7'd0;
        rn.hsigned = 1'b0;
        if (!((lo == S64_MIN) && (hi == S64_MAX)) && !(lo > hi))
        begin
            rn.hvalid = 1'b1;
            if (!lo[63])
            begin
                if (hi <= 64'sd1)                 rn.hwidth = 7'd1;
                else if (hi <= 64'sd255)          rn.hwidth = 7'd8;
                else if (hi <= 64'sd65535)        rn.hwidth = 7'd16;
                else if (hi <= 64'sh0_FFFF_FFFF)  rn.hwidth = 7'd32;
                else                              rn.hwidth = 7'd64;
            end
            else
            begin
                rn.hsigned = 1'b1;
                if (lo >= -64'sd128 && hi <= 64'sd127)            rn.hwidth = 7'd8;
                else if (lo >= -64'sd32768 && hi <= 64'sd32767)   rn.hwidth = 7'd16;
                else if (lo >= -64'sd2147483648 && hi <= 64'sd2147483647)
                    rn.hwidth = 7'd32;
                else
                    rn.hwidth = 7'd64;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= rn;
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {out_reg.hi, out_reg.lo};
    assign m_axis_tuser  = {out_reg.hsigned, out_reg.hwidth, out_reg.hvalid};

    // a stalled result must hold until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // input ready is high whenever the output register is empty
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");
    // hint fields are zero when the hint is invalid
    a_hint: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[8:1] == 8'd0)
        else $error("invalid hint carries data");
endmodule

@@ verif/interval_range_alu_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for interval_range_alu: directed table plus random items.
// Depends on ira_pkg and the interval_range_alu RTL.
module interval_range_alu_tb;
    import ira_pkg::*;

    typedef struct {
        logic [3:0]         op;
        logic signed [63:0] amin;
        logic signed [63:0] amax;
        logic signed [63:0] bmin;
        logic signed [63:0] bmax;
        logic [6:0]         bits;
    } range_op_t;

    typedef struct {
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic               hvalid;
        logic [6:0]         hwidth;
        logic               hsigned;
    } range_res_t;

    typedef struct {
        range_op_t  item;
        bit         fixed;
        range_res_t res;
    } table_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [271:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [8:0]   m_axis_tuser;

    range_res_t expected_q[$];
    int         fail_count = 0;
    int         src_idle_pct;
    int         dst_stall_pct;

    interval_range_alu DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // signed multiply with overflow flag
    function automatic bit mul_overflows(input logic signed [63:0] x,
                                         input logic signed [63:0] y,
                                         output logic signed [63:0] p);
        logic signed [127:0] full;
        begin
            full = 128'(x) * 128'(y);
            p    = full[63:0];
            return full != 128'(p);
        end
    endfunction

    function automatic range_res_t top_range();
        range_res_t r;
        begin
            r.lo = S64_MIN;
            r.hi = S64_MAX;
            r.hvalid = 1'b0;
            r.hwidth = '0;
            r.hsigned = 1'b0;
            return r;
        end
    endfunction

    function automatic void signed_span(input int unsigned n,
                                        output logic signed [63:0] lo,
                                        output logic signed [63:0] hi);
        begin
            if (n == 0) n = 1;
            if (n >= 64)
            begin
                lo = S64_MIN;
                hi = S64_MAX;
            end
            else
            begin
                lo = -(64'sd1 <<< (n - 1));
                hi = (64'sd1 <<< (n - 1)) - 1;
            end
        end
    endfunction

    // expected result interval and narrow-type hint for one item
    function automatic range_res_t predict_range(input range_op_t t);
        range_res_t r;
        logic signed [63:0] lo, hi, wl, wh;
        logic signed [63:0] p[4];
        logic [63:0]        mask, m;
        logic signed [64:0] e0, e1;
        bit                 ovf, atop, btop;
        int unsigned        n, s;
        begin
            r = top_range();
            lo = S64_MIN;
            hi = S64_MAX;
            n = 32'(t.bits);
            atop = (t.amin == S64_MIN) && (t.amax == S64_MAX);
            btop = (t.bmin == S64_MIN) && (t.bmax == S64_MAX);
            case (t.op)
                OP_MEET:
                begin
                    lo = (t.amin > t.bmin) ? t.amin : t.bmin;
                    hi = (t.amax < t.bmax) ? t.amax : t.bmax;
                end
                OP_JOIN:
                begin
                    if (t.amin > t.amax)
                    begin
                        lo = t.bmin;
                        hi = t.bmax;
                    end
                    else if (t.bmin > t.bmax)
                    begin
                        lo = t.amin;
                        hi = t.amax;
                    end
                    else
                    begin
                        lo = (t.amin < t.bmin) ? t.amin : t.bmin;
                        hi = (t.amax > t.bmax) ? t.amax : t.bmax;
                    end
                end
                OP_CONST:
                begin
                    lo = t.amin;
                    hi = t.amin;
                end
                OP_ADD, OP_SUB:
                begin
                    if (!atop && !btop)
                    begin
                        if (t.op == OP_ADD)
                        begin
                            e0 = 65'(t.amin) + 65'(t.bmin);
                            e1 = 65'(t.amax) + 65'(t.bmax);
                        end
                        else
                        begin
                            e0 = 65'(t.amin) - 65'(t.bmax);
                            e1 = 65'(t.amax) - 65'(t.bmin);
                        end
                        if (e0[64] == e0[63] && e1[64] == e1[63])
                        begin
                            lo = e0[63:0];
                            hi = e1[63:0];
                        end
                    end
                end
                OP_MUL:
                begin
                    if (atop || btop)
                        ;
                    else if ((t.amin == 0 && t.amax == 0) || (t.bmin == 0 && t.bmax == 0))
                    begin
                        lo = 0;
                        hi = 0;
                    end
                    else if (t.amin == 1 && t.amax == 1)
                    begin
                        lo = t.bmin;
                        hi = t.bmax;
                    end
                    else if (t.bmin == 1 && t.bmax == 1)
                    begin
                        lo = t.amin;
                        hi = t.amax;
                    end
                    else
                    begin
                        ovf = mul_overflows(t.amin, t.bmin, p[0]);
                        ovf |= mul_overflows(t.amin, t.bmax, p[1]);
                        ovf |= mul_overflows(t.amax, t.bmin, p[2]);
                        ovf |= mul_overflows(t.amax, t.bmax, p[3]);
                        if (!ovf)
                        begin
                            lo = p[0];
                            hi = p[0];
                            for (int i = 1; i < 4; i++)
                            begin
                                if (p[i] < lo) lo = p[i];
                                if (p[i] > hi) hi = p[i];
                            end
                        end
                    end
                end
                OP_AND, OP_OR:
                begin
                    if (t.amin >= 0 && t.bmin >= 0)
                    begin
                        lo = 0;
                        if (t.op == OP_AND)
                            hi = (t.amax < t.bmax) ? t.amax : t.bmax;
                        else
                            hi = t.amax | t.bmax;
                    end
                end
                OP_SHL, OP_SHR:
                begin
                    if (t.bmin == t.bmax && t.bmin >= 0 && t.bmin < 64)
                    begin
                        s = 32'(t.bmin);
                        if (t.op == OP_SHR)
                        begin
                            lo = t.amin >>> s;
                            hi = t.amax >>> s;
                        end
                        else
                        begin
                            // 1<<63 is INT64_MIN as a multiplier
                            ovf = mul_overflows(t.amin, 64'sd1 <<< s, wl);
                            ovf |= mul_overflows(t.amax, 64'sd1 <<< s, wh);
                            if (!ovf)
                            begin
                                lo = wl;
                                hi = wh;
                            end
                        end
                    end
                end
                OP_ZEXT:
                begin
                    mask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
                    m = ($unsigned(t.amax) < mask) ? $unsigned(t.amax) : mask;
                    lo = (t.amin >= 0) ? t.amin : 0;
                    hi = m;
                end
                OP_SEXT:
                begin
                    signed_span(n, wl, wh);
                    lo = (t.amin > wl) ? t.amin : wl;
                    hi = (t.amax < wh) ? t.amax : wh;
                end
                OP_TRUNC:
                begin
                    signed_span(n, wl, wh);
                    if (t.amin >= wl && t.amax <= wh)
                    begin
                        lo = t.amin;
                        hi = t.amax;
                    end
                    else
                    begin
                        lo = wl;
                        hi = wh;
                    end
                end
                OP_UBITS:
                begin
                    lo = 0;
                    hi = (n >= 63) ? S64_MAX : ((64'sd1 <<< n) - 1);
                end
                OP_SBITS:
                    signed_span(n, lo, hi);
                default:
                    ;
            endcase
            r.lo = lo;
            r.hi = hi;
            if (!(lo == S64_MIN && hi == S64_MAX) && !(lo > hi))
            begin
                r.hvalid = 1'b1;
                if (lo >= 0)
                begin
                    if (hi <= 1) r.hwidth = 7'd1;
                    else if (hi <= 64'sh FF) r.hwidth = 7'd8;
                    else if (hi <= 64'sh FFFF) r.hwidth = 7'd16;
                    else if (hi <= 64'sh FFFF_FFFF) r.hwidth = 7'd32;
                    else r.hwidth = 7'd64;
                end
                else
                begin
                    r.hsigned = 1'b1;
                    if (lo >= -128 && hi <= 127) r.hwidth = 7'd8;
                    else if (lo >= -32768 && hi <= 32767) r.hwidth = 7'd16;
                    else if (lo >= -64'sd2147483648 && hi <= 64'sd2147483647)
                        r.hwidth = 7'd32;
                    else r.hwidth = 7'd64;
                end
            end
            return r;
        end
    endfunction

    // bound with a bias towards edges and small magnitudes
    function automatic logic signed [63:0] rand_bound();
        logic signed [63:0] v;
        begin
            case ($urandom_range(0, 9))
                0: v = S64_MIN;
                1: v = S64_MAX;
                2: v = $signed(64'($urandom_range(0, 4))) - 2;
                3, 4: v = $signed(64'($urandom_range(0, 600))) - 300;
                5: v = $signed({{32{1'b0}}, 32'($urandom)}) - 64'sh8000_0000;
                6: v = $signed({{24{1'b0}}, 8'($urandom), 32'($urandom)});
                7: v = -$signed({{34{1'b0}}, 30'($urandom)});
                default: v = {32'($urandom), 32'($urandom)};
            endcase
            return v;
        end
    endfunction

    function automatic range_op_t rand_item();
        range_op_t t;
        logic signed [63:0] x, y;
        begin
            t.op = ($urandom_range(0, 40) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
            x = rand_bound();
            y = rand_bound();
            // mostly well-formed intervals, some empty ones
            if ($urandom_range(0, 7) != 0 && x > y)
            begin
                t.amin = y;
                t.amax = x;
            end
            else
            begin
                t.amin = x;
                t.amax = y;
            end
            x = rand_bound();
            y = rand_bound();
            if ($urandom_range(0, 7) != 0 && x > y)
            begin
                t.bmin = y;
                t.bmax = x;
            end
            else
            begin
                t.bmin = x;
                t.bmax = y;
            end
            if ((t.op == OP_SHL || t.op == OP_SHR || t.op == OP_MUL)
                && $urandom_range(0, 3) != 0)
            begin
                t.bmin = 64'($urandom_range(0, 64));
                t.bmax = t.bmin;
            end
            t.bits = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 65));
            return t;
        end
    endfunction

    // one transaction on the input channel
    task automatic send_item(input range_op_t t, input bit fixed, input range_res_t r);
        begin
            while ($urandom_range(0, 99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {5'd0, t.bits, t.bmax, t.bmin, t.amax, t.amin, t.op};
            expected_q.push_back(fixed ? r : predict_range(t));
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        range_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tdata[63:0] !== e.lo)
                begin
                    $error("res_min expected %0d actual %0d", e.lo, $signed(m_axis_tdata[63:0]));
                    fail_count++;
                end
                if (m_axis_tdata[127:64] !== e.hi)
                begin
                    $error("res_max expected %0d actual %0d", e.hi,
                           $signed(m_axis_tdata[127:64]));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== e.hvalid)
                begin
                    $error("hint_valid expected %0d actual %0d", e.hvalid, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[7:1] !== e.hwidth)
                begin
                    $error("hint_width expected %0d actual %0d", e.hwidth, m_axis_tuser[7:1]);
                    fail_count++;
                end
                if (m_axis_tuser[8] !== e.hsigned)
                begin
                    $error("hint_signed expected %0d actual %0d", e.hsigned, m_axis_tuser[8]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        table_row_t dir_tbl[$];
        table_row_t row;
        range_res_t tp, none;
        int         n_ops;
        tp = top_range();
        none = tp;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        // directed rows: {op, amin, amax, bmin, bmax, bits}, fixed flag, expected
        dir_tbl.push_back('{'{OP_MEET, -5, 10, 0, 20, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_MEET, 0, 3, 5, 9, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_JOIN, 5, 1, -3, 4, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_JOIN, -3, 4, 9, 2, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_CONST, S64_MIN, 0, 0, 0, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_ADD, S64_MIN, S64_MAX, 1, 1, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_ADD, S64_MAX, S64_MAX, 1, 1, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_SUB, S64_MIN, 0, 1, 1, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_MUL, 0, 0, S64_MIN, S64_MAX, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_MUL, 0, 0, -7, 9, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_MUL, 1, 1, -7, 9, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_MUL, -3, 4, -6, 5, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_AND, 3, 300, 0, 70000, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_OR, -1, 3, 0, 5, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_OR, 0, 8, 0, 5, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_SHL, -1, 0, 63, 63, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_SHL, 1, 2, 64, 64, 7'd0}, 1, tp});
        dir_tbl.push_back('{'{OP_SHR, S64_MIN, S64_MAX - 1, 63, 63, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_ZEXT, -9, -1, 0, 0, 7'd8}, 0, none});
        dir_tbl.push_back('{'{OP_SEXT, S64_MIN, S64_MAX, 0, 0, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_TRUNC, -5, 5, 0, 0, 7'd127}, 0, none});
        dir_tbl.push_back('{'{OP_UBITS, 0, 0, 0, 0, 7'd0}, 0, none});
        dir_tbl.push_back('{'{OP_UBITS, 0, 0, 0, 0, 7'd63}, 0, none});
        dir_tbl.push_back('{'{OP_SBITS, 0, 0, 0, 0, 7'd64}, 1, tp});
        dir_tbl.push_back('{'{4'd15, 0, 0, 0, 0, 7'd0}, 1, tp});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            row = dir_tbl[i];
            send_item(row.item, row.fixed, row.res);
        end

        // random phases with different idling
        n_ops = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 47) : 0;
            dst_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 47) : 0;
            repeat (290)
            begin
                send_item(rand_item(), 0, none);
                n_ops++;
                if (n_ops == 500)
                begin
                    // let the pipe drain completely
                    s_axis_tvalid <= 1'b0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
